### rtl/dcc_pkg.sv
// Shared constants and controller/datapath interface types for the duplicate column classifier.
package dcc_pkg;

   localparam int DCC_MAX_CLASSES      = 256;
   localparam int DCC_MAX_ATTRIBUTES   = 1024;
   localparam int DCC_WORDS_PER_COLUMN = 4;

   localparam int CLASS_ID_W = 8;
   localparam int REP_ATTR_W = 10;
   localparam int WORD_W     = 64;

   typedef struct packed {
      logic take;
      logic step_word;
      logic skip_class;
      logic hit;
      logic open_class;
      logic miss_full;
      logic wr_word;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic col_end;
      logic scan_done;
      logic word_match;
      logic last_pos;
      logic table_full;
      logic out_free;
   } sts_type;

endpackage

### rtl/dcc_ctrl.sv
// Controller state machine: request intake, class table scan, class opening and result hand-off.
module dcc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dcc_pkg::sts_type sts,
   output dcc_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_CMP,
      ST_WR,
      ST_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && sts.col_end) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (sts.scan_done) begin
               if (sts.table_full) begin
                  cmd.miss_full = 1'b1;
                  state_in      = ST_FIN;
               end else begin
                  cmd.open_class = 1'b1;
                  state_in       = ST_WR;
               end
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            priority if (!sts.word_match) begin
               cmd.skip_class = 1'b1;
               state_in       = ST_RD;
            end else if (sts.last_pos) begin
               cmd.hit  = 1'b1;
               state_in = ST_FIN;
            end else begin
               cmd.step_word = 1'b1;
               state_in      = ST_RD;
            end
         end
         ST_WR: begin
            cmd.wr_word = 1'b1;
            if (sts.last_pos) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/dcc_datapath.sv
// Datapath: column buffer, class column and representative memories, counters and result register.
module dcc_datapath #(
   parameter int MAX_CLASSES      = dcc_pkg::DCC_MAX_CLASSES,
   parameter int MAX_ATTRIBUTES   = dcc_pkg::DCC_MAX_ATTRIBUTES,
   parameter int WORDS_PER_COLUMN = dcc_pkg::DCC_WORDS_PER_COLUMN
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [dcc_pkg::WORD_W-1:0]       req_column_word,
   input  logic                             req_last_word,
   input  logic                             req_new_context,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [dcc_pkg::CLASS_ID_W-1:0]   rsp_class_id,
   output logic [dcc_pkg::REP_ATTR_W-1:0]   rsp_representative_attr,
   output logic                             rsp_new_class,
   output logic                             rsp_table_full,
   input  dcc_pkg::cmd_type                 cmd,
   output dcc_pkg::sts_type                 sts
);

   localparam int CLS_W  = $clog2(MAX_CLASSES);
   localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
   localparam int ATTR_W = $clog2(MAX_ATTRIBUTES);
   localparam int POS_W  = (WORDS_PER_COLUMN > 1) ? $clog2(WORDS_PER_COLUMN) : 1;
   localparam int DEPTH  = MAX_CLASSES * WORDS_PER_COLUMN;
   localparam int AW     = $clog2(DEPTH);

   logic [dcc_pkg::WORD_W-1:0] pend_ff [WORDS_PER_COLUMN];
   logic [dcc_pkg::WORD_W-1:0] store [DEPTH];
   logic [ATTR_W-1:0]          rep_mem [MAX_CLASSES];

   logic [dcc_pkg::WORD_W-1:0] rd_ff;
   logic [ATTR_W-1:0]          rep_rd_ff;

   logic [POS_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [CNT_W-1:0]  cls_ff;
   logic [POS_W-1:0]  sp_ff;
   logic [AW-1:0]     addr_ff;

   logic [CNT_W-1:0]  res_cls_ff;
   logic [ATTR_W-1:0] res_rep_ff;
   logic              res_new_ff;
   logic              res_full_ff;

   logic                           rsp_valid_ff;
   logic [dcc_pkg::CLASS_ID_W-1:0] rsp_class_id_ff;
   logic [dcc_pkg::REP_ATTR_W-1:0] rsp_rep_ff;
   logic                           rsp_new_ff;
   logic                           rsp_full_ff;

   logic [POS_W-1:0]  pos_eff;
   logic              sp_last;
   logic [31:0]       cls_ext;
   logic [31:0]       rep_ext;
   logic [AW-1:0]     skip_addr;

   assign pos_eff   = req_new_context ? '0 : pos_ff;
   assign sp_last   = (sp_ff == POS_W'(WORDS_PER_COLUMN - 1));
   assign cls_ext   = 32'(res_cls_ff);
   assign rep_ext   = 32'(res_rep_ff);
   assign skip_addr = addr_ff + AW'(WORDS_PER_COLUMN) - AW'(sp_ff);

   assign sts.col_end    = req_last_word || (pos_eff == POS_W'(WORDS_PER_COLUMN - 1));
   assign sts.scan_done  = (cls_ff == cnt_ff);
   assign sts.word_match = (rd_ff == pend_ff[sp_ff]);
   assign sts.last_pos   = sp_last;
   assign sts.table_full = (cnt_ff == CNT_W'(MAX_CLASSES));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         for (int i = 0; i < WORDS_PER_COLUMN; i++) begin
            if (POS_W'(i) == pos_eff) begin
               pend_ff[i] <= req_column_word;
            end else if (pos_eff == '0) begin
               pend_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_word) begin
         store[addr_ff] <= pend_ff[sp_ff];
      end
      rd_ff <= store[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.open_class) begin
         rep_mem[cnt_ff[CLS_W-1:0]] <= attr_ff;
      end
      rep_rd_ff <= rep_mem[cls_ff[CLS_W-1:0]];
   end

   always_ff @(posedge clock) begin
      priority if (cmd.hit) begin
         res_cls_ff  <= cls_ff;
         res_rep_ff  <= rep_rd_ff;
         res_new_ff  <= 1'b0;
         res_full_ff <= 1'b0;
      end else if (cmd.open_class) begin
         res_cls_ff  <= cnt_ff;
         res_rep_ff  <= attr_ff;
         res_new_ff  <= 1'b1;
         res_full_ff <= 1'b0;
      end else if (cmd.miss_full) begin
         res_cls_ff  <= '0;
         res_rep_ff  <= '0;
         res_new_ff  <= 1'b0;
         res_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_class_id_ff <= cls_ext[dcc_pkg::CLASS_ID_W-1:0];
         rsp_rep_ff      <= rep_ext[dcc_pkg::REP_ATTR_W-1:0];
         rsp_new_ff      <= res_new_ff;
         rsp_full_ff     <= res_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cnt_ff       <= '0;
         attr_ff      <= '0;
         cls_ff       <= '0;
         sp_ff        <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take) begin
            if (req_new_context) begin
               cnt_ff  <= '0;
               attr_ff <= '0;
            end
            pos_ff <= sts.col_end ? '0 : pos_eff + POS_W'(1);
            if (sts.col_end) begin
               cls_ff  <= '0;
               sp_ff   <= '0;
               addr_ff <= '0;
            end
         end
         if (cmd.step_word || cmd.wr_word) begin
            sp_ff   <= sp_last ? '0 : sp_ff + POS_W'(1);
            addr_ff <= addr_ff + AW'(1);
         end
         if (cmd.skip_class) begin
            cls_ff  <= cls_ff + CNT_W'(1);
            sp_ff   <= '0;
            addr_ff <= skip_addr;
         end
         if (cmd.commit) begin
            cnt_ff  <= cnt_ff + CNT_W'(res_new_ff);
            attr_ff <= (attr_ff == ATTR_W'(MAX_ATTRIBUTES - 1)) ? '0 : attr_ff + ATTR_W'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_class_id            = rsp_class_id_ff;
   assign rsp_representative_attr = rsp_rep_ff;
   assign rsp_new_class           = rsp_new_ff;
   assign rsp_table_full          = rsp_full_ff;

endmodule

### rtl/duplicate_column_classifier_top.sv
// Top level of the duplicate column classifier: controller, datapath and checks.
// Use: each request carries one 64-bit word of an attribute's column, first word first.
// A column ends on req_last_word or on its WORDS_PER_COLUMN-th word; missing words are zero.
// req_new_context on a request clears the class table and attribute counter first.
// One response per finished column: class id, representative attribute, new_class and
// table_full (class id and representative zero when full).
// Words that do not end a column are taken one per cycle while no column end is in progress.
// A column-ending word stalls the request channel while the class memory is scanned:
// each stored word compared takes a memory read and a compare, and a mismatch skips the rest
// of that class; on a miss with room a new class is stored word by word, and the response
// is then loaded. The scan is bound by the single read port of the class column memory.
// The response register frees the request side: new words are taken while a response waits;
// only the next column end waits in its final step until the response is taken.
// Reset empties the class table, zeroes the attribute counter and drops any partial column;
// memories are not cleared, so the block is ready the cycle after reset.
// A stalled response holds its value until rsp_stall drops.
module duplicate_column_classifier_top #(
   parameter int MAX_CLASSES      = dcc_pkg::DCC_MAX_CLASSES,
   parameter int MAX_ATTRIBUTES   = dcc_pkg::DCC_MAX_ATTRIBUTES,
   parameter int WORDS_PER_COLUMN = dcc_pkg::DCC_WORDS_PER_COLUMN
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dcc_pkg::WORD_W-1:0]     req_column_word,
   input  logic                           req_last_word,
   input  logic                           req_new_context,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dcc_pkg::CLASS_ID_W-1:0] rsp_class_id,
   output logic [dcc_pkg::REP_ATTR_W-1:0] rsp_representative_attr,
   output logic                           rsp_new_class,
   output logic                           rsp_table_full
);

   dcc_pkg::cmd_type cmd;
   dcc_pkg::sts_type sts;

   dcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dcc_datapath #(
      .MAX_CLASSES      (MAX_CLASSES),
      .MAX_ATTRIBUTES   (MAX_ATTRIBUTES),
      .WORDS_PER_COLUMN (WORDS_PER_COLUMN)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .req_column_word         (req_column_word),
      .req_last_word           (req_last_word),
      .req_new_context         (req_new_context),
      .rsp_stall               (rsp_stall),
      .rsp_valid               (rsp_valid),
      .rsp_class_id            (rsp_class_id),
      .rsp_representative_attr (rsp_representative_attr),
      .rsp_new_class           (rsp_new_class),
      .rsp_table_full          (rsp_table_full),
      .cmd                     (cmd),
      .sts                     (sts)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("response loaded over a stalled response");

   a_open_room: assert property (@(posedge clock) disable iff (reset)
      cmd.open_class |-> !sts.table_full)
      else $error("class opened with a full table");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("response raised without a commit");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_word || cmd.step_word || cmd.skip_class) |-> !cmd.take)
      else $error("request taken during a scan");

endmodule

### tb/sv/column_class_checker.sv
`timescale 1ns / 1ps
// Response checker for the duplicate column classifier: predicts class verdicts and compares.
module column_class_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [dcc_pkg::WORD_W-1:0]     req_column_word,
   input  logic                           req_last_word,
   input  logic                           req_new_context,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [dcc_pkg::CLASS_ID_W-1:0] rsp_class_id,
   input  logic [dcc_pkg::REP_ATTR_W-1:0] rsp_representative_attr,
   input  logic                           rsp_new_class,
   input  logic                           rsp_table_full,
   output int                             fail_count,
   output int                             verdicts_waiting,
   output int                             columns_checked,
   output int                             classes_opened,
   output int                             full_verdicts
);

   localparam int NCLASS = dcc_pkg::DCC_MAX_CLASSES;
   localparam int NATTR  = dcc_pkg::DCC_MAX_ATTRIBUTES;
   localparam int NWORD  = dcc_pkg::DCC_WORDS_PER_COLUMN;

   typedef struct packed {
      logic [dcc_pkg::CLASS_ID_W-1:0] class_id;
      logic [dcc_pkg::REP_ATTR_W-1:0] rep_attr;
      logic                           new_class;
      logic                           table_full;
   } verdict_type;

   logic [dcc_pkg::WORD_W-1:0]     class_columns [NCLASS][NWORD];
   logic [dcc_pkg::REP_ATTR_W-1:0] class_reps [NCLASS];
   bit                             still_matching [NCLASS];
   logic [dcc_pkg::WORD_W-1:0]     column_words [NWORD];
   int unsigned                    word_slot;
   int unsigned                    class_total;
   int unsigned                    attr_index;
   verdict_type                    expected_verdicts [$];

   task automatic clear_candidates();
      for (int c = 0; c < NCLASS; c++) still_matching[c] = 1'b1;
      for (int i = 0; i < NWORD; i++) column_words[i] = '0;
      word_slot = 0;
   endtask

   task automatic narrow_candidates(input int unsigned slot,
                                    input logic [dcc_pkg::WORD_W-1:0] w);
      for (int c = 0; c < class_total; c++) begin
         if (still_matching[c] && class_columns[c][slot] != w) still_matching[c] = 1'b0;
      end
   endtask

   task automatic classify_word(input logic [dcc_pkg::WORD_W-1:0] w, input logic last,
                                input logic fresh);
      int unsigned slot;
      int          found;
      verdict_type v;
      if (fresh) begin
         class_total = 0;
         attr_index  = 0;
         clear_candidates();
      end
      slot = (word_slot >= NWORD) ? NWORD - 1 : word_slot;
      column_words[slot] = w;
      narrow_candidates(slot, w);
      if (!last && slot + 1 < NWORD) begin
         word_slot = slot + 1;
      end else begin
         // treat missing words of a short column as zero
         for (int s = slot + 1; s < NWORD; s++) narrow_candidates(s, '0);
         found = -1;
         for (int c = 0; c < class_total; c++) begin
            if (found < 0 && still_matching[c]) found = c;
         end
         v = '0;
         if (found >= 0) begin
            v.class_id = found[dcc_pkg::CLASS_ID_W-1:0];
            v.rep_attr = class_reps[found];
         end else if (class_total < NCLASS) begin
            for (int i = 0; i < NWORD; i++) class_columns[class_total][i] = column_words[i];
            class_reps[class_total] = attr_index[dcc_pkg::REP_ATTR_W-1:0];
            v.class_id  = class_total[dcc_pkg::CLASS_ID_W-1:0];
            v.rep_attr  = attr_index[dcc_pkg::REP_ATTR_W-1:0];
            v.new_class = 1'b1;
            class_total++;
         end else begin
            v.table_full = 1'b1;
         end
         expected_verdicts.push_back(v);
         attr_index = (attr_index + 1 >= NATTR) ? 0 : attr_index + 1;
         clear_candidates();
      end
   endtask

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch at response %0d: %s", $time, columns_checked, msg);
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         class_total = 0;
         attr_index  = 0;
         clear_candidates();
         expected_verdicts.delete();
         fail_count       = 0;
         verdicts_waiting = 0;
         columns_checked  = 0;
         classes_opened   = 0;
         full_verdicts    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            classify_word(req_column_word, req_last_word, req_new_context);
         end
         if (rsp_valid && !rsp_stall) begin
            columns_checked++;
            if (rsp_new_class === 1'b1) classes_opened++;
            if (rsp_table_full === 1'b1) full_verdicts++;
            if (expected_verdicts.size() == 0) begin
               report_mismatch("response with no column pending");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_class_id !== want.class_id)
                  report_mismatch($sformatf("class_id got %0d want %0d",
                                            rsp_class_id, want.class_id));
               if (rsp_representative_attr !== want.rep_attr)
                  report_mismatch($sformatf("representative_attr got %0d want %0d",
                                            rsp_representative_attr, want.rep_attr));
               if (rsp_new_class !== want.new_class)
                  report_mismatch($sformatf("new_class got %0b want %0b",
                                            rsp_new_class, want.new_class));
               if (rsp_table_full !== want.table_full)
                  report_mismatch($sformatf("table_full got %0b want %0b",
                                            rsp_table_full, want.table_full));
            end
         end
         verdicts_waiting = expected_verdicts.size();
      end
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the duplicate column classifier: clock, reset, column stimulus and verdict.
module tb_top;

   localparam int NWORD        = dcc_pkg::DCC_WORDS_PER_COLUMN;
   localparam int CYCLE_LIMIT  = 50_000_000;
   localparam int DRAIN_CYCLES = 2 * NWORD * dcc_pkg::DCC_MAX_CLASSES + NWORD + 16;

   typedef logic [NWORD-1:0][dcc_pkg::WORD_W-1:0] column_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [dcc_pkg::WORD_W-1:0]     req_column_word;
   logic                           req_last_word;
   logic                           req_new_context;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [dcc_pkg::CLASS_ID_W-1:0] rsp_class_id;
   logic [dcc_pkg::REP_ATTR_W-1:0] rsp_representative_attr;
   logic                           rsp_new_class;
   logic                           rsp_table_full;

   int fail_count;
   int verdicts_waiting;
   int columns_checked;
   int classes_opened;
   int full_verdicts;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int requests_sent = 0;
   int cycle_count   = 0;

   duplicate_column_classifier_top DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_column_word         (req_column_word),
      .req_last_word           (req_last_word),
      .req_new_context         (req_new_context),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_class_id            (rsp_class_id),
      .rsp_representative_attr (rsp_representative_attr),
      .rsp_new_class           (rsp_new_class),
      .rsp_table_full          (rsp_table_full)
   );

   column_class_checker verdict_check (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_column_word         (req_column_word),
      .req_last_word           (req_last_word),
      .req_new_context         (req_new_context),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_class_id            (rsp_class_id),
      .rsp_representative_attr (rsp_representative_attr),
      .rsp_new_class           (rsp_new_class),
      .rsp_table_full          (rsp_table_full),
      .fail_count              (fail_count),
      .verdicts_waiting        (verdicts_waiting),
      .columns_checked         (columns_checked),
      .classes_opened          (classes_opened),
      .full_verdicts           (full_verdicts)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [dcc_pkg::WORD_W-1:0] pick_word();
      unique case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   function automatic column_type build_column(input column_type base, input logic have_base);
      column_type col;
      int         keep;
      for (int i = 0; i < NWORD; i++) col[i] = pick_word();
      if (have_base && $urandom_range(0, 2) != 0) begin
         col = base;
         col[$urandom_range(0, NWORD - 1)] = pick_word();
      end
      // zero the tail so a short column can match it
      if ($urandom_range(0, 2) == 0) begin
         keep = $urandom_range(1, NWORD - 1);
         for (int i = keep; i < NWORD; i++) col[i] = '0;
      end
      return col;
   endfunction

   task automatic send_word(input logic [dcc_pkg::WORD_W-1:0] w, input logic last,
                            input logic fresh);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid       = 1'b0;
         req_column_word = {$urandom, $urandom};
         req_last_word   = $urandom_range(0, 1);
         req_new_context = $urandom_range(0, 1);
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_column_word = w;
      req_last_word   = last;
      req_new_context = fresh;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_column(input column_type col, input int len, input logic mark_last,
                              input logic fresh);
      for (int i = 0; i < len; i++) begin
         send_word(col[i], mark_last && i == len - 1, fresh && i == 0);
      end
   endtask

   task automatic run_directed();
      column_type a;
      column_type b;
      a = {64'h0123456789abcdef, 64'hfedcba9876543210,
           64'h5555555555555555, 64'haaaaaaaaaaaaaaaa};
      send_word('1, 1'b1, 1'b1);
      send_column('0, NWORD, 1'b1, 1'b0);
      // early last word: matches the all-zero column
      send_word('0, 1'b1, 1'b0);
      send_word('1, 1'b1, 1'b0);
      // long column without a last word, then the same column properly closed
      send_column(a, NWORD, 1'b0, 1'b0);
      send_column(a, NWORD, 1'b1, 1'b0);
      b = a;
      b[NWORD-1] = ~b[NWORD-1];
      send_column(b, NWORD, 1'b1, 1'b0);
      b = a;
      b[0] = '0;
      send_column(b, NWORD, 1'b1, 1'b0);
      // drop a partial column with a new context
      send_column(a, 2, 1'b0, 1'b0);
      send_column(a, NWORD, 1'b1, 1'b1);
      send_word(64'h8000000000000001, 1'b1, 1'b0);
      b = '0;
      b[0] = 64'h8000000000000001;
      send_column(b, NWORD, 1'b1, 1'b0);
      send_column(a, 3, 1'b1, 1'b0);
      send_column(a, 3, 1'b1, 1'b0);
   endtask

   task automatic run_contexts(input int budget);
      int         start_count;
      int         ncols;
      int         style;
      int         len;
      int         nz;
      logic       fresh_next;
      logic       cut;
      column_type col;
      column_type pool [$];
      start_count = requests_sent;
      while (requests_sent - start_count < budget) begin
         pool.delete();
         repeat ($urandom_range(1, 10)) begin
            if (pool.size() > 0)
               pool.push_back(build_column(pool[$urandom_range(0, pool.size() - 1)], 1'b1));
            else
               pool.push_back(build_column('0, 1'b0));
         end
         ncols = $urandom_range(4, 40);
         fresh_next = 1'b1;
         for (int k = 0; k < ncols && requests_sent - start_count < budget; k++) begin
            if ($urandom_range(0, 9) == 0)
               col = build_column(pool[0], 1'b1);
            else
               col = pool[$urandom_range(0, pool.size() - 1)];
            style = $urandom_range(0, 99);
            cut = 1'b0;
            if (style < 55) begin
               send_column(col, NWORD, 1'b1, fresh_next);
            end else if (style < 70) begin
               send_column(col, NWORD, 1'b0, fresh_next);
            end else if (style < 88) begin
               nz = 0;
               for (int i = 0; i < NWORD; i++) if (col[i] != '0) nz = i + 1;
               if (nz == 0) nz = 1;
               len = (nz < NWORD && $urandom_range(0, 1)) ? nz : $urandom_range(1, NWORD - 1);
               send_column(col, len, 1'b1, fresh_next);
            end else if (style < 95) begin
               send_column(col, $urandom_range(1, NWORD - 1), 1'b0, fresh_next);
               cut = 1'b1;
            end else begin
               send_word(pick_word(), $urandom_range(0, 1), fresh_next);
            end
            fresh_next = cut;
         end
      end
   endtask

   task automatic fill_class_table();
      logic [dcc_pkg::WORD_W-1:0] w;
      logic [dcc_pkg::WORD_W-1:0] stored [$];
      for (int k = 0; k < dcc_pkg::DCC_MAX_CLASSES + 8; k++) begin
         if (k >= dcc_pkg::DCC_MAX_CLASSES && k % 2 == 1)
            w = stored[$urandom_range(0, stored.size() - 1)];
         else
            w = {$urandom, $urandom};
         if (k < dcc_pkg::DCC_MAX_CLASSES) stored.push_back(w);
         send_word(w, 1'b1, k == 0);
      end
   endtask

   task automatic wrap_attribute_counter();
      logic [dcc_pkg::WORD_W-1:0] few [5];
      logic [dcc_pkg::WORD_W-1:0] w;
      for (int i = 0; i < 5; i++) few[i] = pick_word();
      for (int k = 0; k < dcc_pkg::DCC_MAX_ATTRIBUTES + 6; k++) begin
         if (k == dcc_pkg::DCC_MAX_ATTRIBUTES + 2)
            w = {$urandom, $urandom};
         else
            w = few[$urandom_range(0, 4)];
         send_word(w, 1'b1, k == 0);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_column_word = '0;
      req_last_word   = 1'b0;
      req_new_context = 1'b0;
      rsp_stall       = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      for (int p = 0; p < 4; p++) begin
         unique case (p)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 65;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 65;
            end
            default: begin
               req_idle_pct  = 20;
               rsp_stall_pct = 20;
            end
         endcase
         run_contexts(120);
         if (p == 1) wrap_attribute_counter();
         if (p == 3) fill_class_table();
      end
      req_valid = 1'b0;
      wait (verdicts_waiting == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d column words over four traffic phases; %0d columns classified.",
               requests_sent, columns_checked);
      $display("%0d responses opened a class, %0d hit a full class table.",
               classes_opened, full_verdicts);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
